### rtl/bct_pkg.sv
// Shared constants for the cubic Bezier tessellator: store geometry, field widths,
// multiplier operand widths, item action codes and configuration register indexes.
// No dependencies.
`default_nettype none

package bct_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int STORE_DEPTH  = 3 * MAX_SEGMENTS + 1;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  localparam int COORD_W = 16;
  localparam int INDEX_W = 6;
  localparam int PPS_W   = 6;
  localparam int SEG_W   = 5;
  localparam int CFG_W   = 6;

  // The parameter t is Q0.16; one full unit needs 17 bits.
  localparam int QUO_W = 17;
  localparam logic [QUO_W-1:0] T_ONE = QUO_W'(1) << (QUO_W - 1);

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_TESS  = 2'd2;

  localparam logic CFG_PPS       = 1'b0;
  localparam logic CFG_SEG_COUNT = 1'b1;

  localparam logic [PPS_W-1:0] PPS_RESET = PPS_W'(16);

endpackage

`default_nettype wire

### rtl/cubic_bezier_tessellator_core.sv
// Cubic Bezier tessellator top level: control point store, sequencer, shared multiplier.
// A write or an out-of-range item goes from acceptance to S_PUT and on to the output
// registers, a read through S_RD first. A tessellation runs S_LOAD and S_DIV, then
// S_MUL and S_PUT for each of its N samples; the last segment gives its end point as
// one more word. Each sample needs 23 products on the one 33x17 multiplier; one item is in work at a time.
// Reset: synchronous, clears the sequencer; samples 16, segments 0; store contents undefined.
`default_nettype none

module cubic_bezier_tessellator_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire logic [1:0]                          action,
  input  wire logic [bct_pkg::INDEX_W-1:0]         index,
  input  wire logic signed [bct_pkg::COORD_W-1:0]  coord_x,
  input  wire logic signed [bct_pkg::COORD_W-1:0]  coord_y,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic signed [bct_pkg::COORD_W-1:0]       point_x,
  output logic signed [bct_pkg::COORD_W-1:0]       point_y,
  output logic                                     last,
  output logic                                     status,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic                                cfg_index,
  input  wire logic [bct_pkg::CFG_W-1:0]           cfg_data
);

  localparam int STEP_W      = 5;
  localparam int APPLY_FIRST = 7;
  localparam int ISSUE_LAST  = 22;
  localparam int STEP_DONE   = 24;
  localparam int LOAD_LAST   = 4;
  localparam int W_W         = 49;
  localparam int ACC_W       = 64;
  localparam int CW          = bct_pkg::COORD_W;
  localparam int AW          = bct_pkg::ADDR_W;
  localparam int PW          = bct_pkg::PPS_W;
  localparam logic [CW-1:0] SIGN_FLIP = CW'(1) << (CW - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_LOAD = 6'b000100,
    S_DIV  = 6'b001000,
    S_MUL  = 6'b010000,
    S_PUT  = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_UU, DST_UT, DST_TT, DST_W0, DST_W1, DST_W2, DST_W3,
    DST_XLO, DST_XHI, DST_YLO, DST_YHI
  } dest_t;

  state_t state;
  dest_t  prod_dest;
  dest_t  dest_sel;

  logic [PW-1:0]             pps;
  logic [bct_pkg::SEG_W-1:0] seg_count;
  logic [bct_pkg::SEG_W-1:0] nseg;
  logic [bct_pkg::SEG_W+1:0] npts;
  logic                      pt_ok;
  logic                      seg_ok;
  logic                      seg_last;
  logic                      bad_item;
  logic [AW-1:0]             base;
  logic [PW-1:0]             pps_eff;
  logic [PW-1:0]             pps_m1;

  logic                      accept;
  logic                      slot_free;
  logic                      push;
  logic                      push_p3;
  logic                      push_next;
  logic                      last_sample;

  logic [STEP_W-1:0]         step;
  logic [STEP_W-1:0]         apply_sel;
  logic [2:0]                ld_cnt;
  logic [PW-1:0]             k;
  logic [15:0]               t;
  logic [PW-1:0]             rem_t;
  logic [bct_pkg::QUO_W-1:0] u;
  logic [PW:0]               rem_sum;
  logic                      t_carry;
  logic                      is_last_seg;
  logic [AW-1:0]             base_r;

  logic [CW-1:0]             bx [4];
  logic [CW-1:0]             by [4];
  logic [32:0]               uu;
  logic [31:0]               ut;
  logic [31:0]               tt;
  logic [W_W-1:0]            w [4];
  logic [ACC_W-1:0]          acc_x;
  logic [ACC_W-1:0]          acc_y;
  logic [CW-1:0]             rnd_x;
  logic [CW-1:0]             rnd_y;

  logic [CW-1:0]             pend_x;
  logic [CW-1:0]             pend_y;
  logic                      pend_last;
  logic                      pend_status;

  logic                      mem_we;
  logic [AW-1:0]             raddr;
  logic [CW-1:0]             rd_x;
  logic [CW-1:0]             rd_y;

  logic                      div_start;
  logic                      div_done;
  logic [bct_pkg::QUO_W-1:0] div_quo;
  logic [PW-1:0]             div_rem;

  logic                        issue;
  logic [1:0]                  term;
  logic [bct_pkg::MUL_A_W-1:0] mul_a;
  logic [bct_pkg::MUL_B_W-1:0] mul_b;
  logic [bct_pkg::MUL_P_W-1:0] prod;

  // Decode of the incoming word against the configured segment count.
  always_comb begin
    nseg = (int'(seg_count) > bct_pkg::MAX_SEGMENTS) ?
           bct_pkg::SEG_W'(bct_pkg::MAX_SEGMENTS) : seg_count;
    npts     = {1'b0, nseg, 1'b0} + {2'b00, nseg} + (bct_pkg::SEG_W + 2)'(1);
    pt_ok    = {1'b0, index} < npts;
    seg_ok   = index < {1'b0, nseg};
    seg_last = (index + bct_pkg::INDEX_W'(1)) == {1'b0, nseg};
    base     = AW'({index, 1'b0}) + AW'(index);
    pps_eff  = (pps == '0) ? PW'(1) : pps;
    pps_m1   = pps_eff - PW'(1);
    case (action)
      bct_pkg::ACT_WRITE: bad_item = !pt_ok;
      bct_pkg::ACT_READ:  bad_item = !pt_ok;
      bct_pkg::ACT_TESS:  bad_item = !seg_ok;
      default:            bad_item = 1'b1;
    endcase
  end

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign mem_we     = accept && (action == bct_pkg::ACT_WRITE) && pt_ok;
  assign div_start  = accept && (action == bct_pkg::ACT_TESS) && seg_ok;
  assign raddr      = (state == S_LOAD) ? base_r + AW'(ld_cnt[1:0]) : AW'(index);

  assign slot_free   = !result_valid || !result_stall;
  assign last_sample = (k == pps_m1);
  assign push        = (state == S_PUT) && slot_free;
  assign push_p3     = push && !pend_last && last_sample;
  assign push_next   = push && !pend_last && !last_sample;

  // Running t = floor(k * 2^16 / N), kept as quotient steps plus a remainder.
  always_comb begin
    u       = bct_pkg::T_ONE - {1'b0, t};
    rem_sum = {1'b0, rem_t} + {1'b0, div_rem};
    t_carry = rem_sum >= {1'b0, pps_eff};
    rnd_x   = acc_x[ACC_W-1:ACC_W-CW] + CW'(acc_x[ACC_W-CW-1]);
    rnd_y   = acc_y[ACC_W-1:ACC_W-CW] + CW'(acc_y[ACC_W-CW-1]);
  end

  // Multiplier schedule for one sample: the powers of u and t, then the four
  // Bernstein weights, then each weight against each biased control coordinate
  // in a low and a high half.
  always_comb begin
    apply_sel = step - STEP_W'(APPLY_FIRST);
    term      = apply_sel[2:1];
    mul_a     = '0;
    mul_b     = '0;
    dest_sel  = DST_NONE;
    case (step)
      STEP_W'(0): begin
        mul_a = bct_pkg::MUL_A_W'(u);  mul_b = u;            dest_sel = DST_UU;
      end
      STEP_W'(1): begin
        mul_a = bct_pkg::MUL_A_W'(u);  mul_b = {1'b0, t};    dest_sel = DST_UT;
      end
      STEP_W'(2): begin
        mul_a = bct_pkg::MUL_A_W'(t);  mul_b = {1'b0, t};    dest_sel = DST_TT;
      end
      STEP_W'(3): begin
        mul_a = uu;                    mul_b = u;            dest_sel = DST_W0;
      end
      STEP_W'(4): begin
        mul_a = uu;                    mul_b = {1'b0, t};    dest_sel = DST_W1;
      end
      STEP_W'(5): begin
        mul_a = bct_pkg::MUL_A_W'(ut); mul_b = {1'b0, t};    dest_sel = DST_W2;
      end
      STEP_W'(6): begin
        mul_a = bct_pkg::MUL_A_W'(tt); mul_b = {1'b0, t};    dest_sel = DST_W3;
      end
      default: begin
        if (step <= STEP_W'(ISSUE_LAST)) begin
          mul_a = apply_sel[0] ? bct_pkg::MUL_A_W'(w[term][W_W-1:bct_pkg::MUL_A_W])
                               : w[term][bct_pkg::MUL_A_W-1:0];
          mul_b = {1'b0, apply_sel[3] ? by[term] : bx[term]};
          case (apply_sel[3:0] & 4'b1001)
            4'b0000: dest_sel = DST_XLO;
            4'b0001: dest_sel = DST_XHI;
            4'b1000: dest_sel = DST_YLO;
            default: dest_sel = DST_YHI;
          endcase
        end
      end
    endcase
  end

  assign issue = (state == S_MUL) && (step <= STEP_W'(ISSUE_LAST));

  bct_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(index)),
    .wr_x  (coord_x),
    .wr_y  (coord_y),
    .raddr (raddr),
    .rd_x  (rd_x),
    .rd_y  (rd_y)
  );

  bct_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  bct_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .divisor   (pps_eff),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  // Sequencer and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      ld_cnt       <= '0;
      k            <= '0;
      prod_dest    <= DST_NONE;
      result_valid <= 1'b0;
      pps          <= bct_pkg::PPS_RESET;
      seg_count    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bct_pkg::CFG_PPS:       pps       <= cfg_data[PW-1:0];
          bct_pkg::CFG_SEG_COUNT: seg_count <= cfg_data[bct_pkg::SEG_W-1:0];
          default: ;
        endcase
      end

      prod_dest <= issue ? dest_sel : DST_NONE;

      if (push) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (bad_item) begin
              state <= S_PUT;
            end else begin
              case (action)
                bct_pkg::ACT_READ: state <= S_RD;
                bct_pkg::ACT_TESS: begin
                  state  <= S_LOAD;
                  ld_cnt <= '0;
                  k      <= '0;
                end
                default: state <= S_PUT;
              endcase
            end
          end
        end
        S_RD: state <= S_PUT;
        S_LOAD: begin
          ld_cnt <= ld_cnt + 3'd1;
          if (ld_cnt == 3'(LOAD_LAST)) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
            step  <= '0;
          end
        end
        S_MUL: begin
          if (step == STEP_W'(STEP_DONE)) begin
            state <= S_PUT;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_PUT: begin
          if (push) begin
            if (pend_last) begin
              state <= S_IDLE;
            end else if (!last_sample) begin
              k     <= k + PW'(1);
              step  <= '0;
              state <= S_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item payload, control point copies and the pending result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      is_last_seg <= seg_last;
      base_r      <= base;
      t           <= '0;
      rem_t       <= '0;
      pend_x      <= '0;
      pend_y      <= '0;
      pend_last   <= 1'b1;
      pend_status <= bad_item;
    end
    if (state == S_RD) begin
      pend_x <= rd_x;
      pend_y <= rd_y;
    end
    // Read data is registered, so capture runs one count behind the address.
    if ((state == S_LOAD) && (ld_cnt != 3'd0)) begin
      bx[2'(ld_cnt - 3'd1)] <= rd_x ^ SIGN_FLIP;
      by[2'(ld_cnt - 3'd1)] <= rd_y ^ SIGN_FLIP;
    end
    if ((state == S_MUL) && (step == STEP_W'(STEP_DONE))) begin
      pend_x      <= rnd_x ^ SIGN_FLIP;
      pend_y      <= rnd_y ^ SIGN_FLIP;
      pend_last   <= !is_last_seg && last_sample;
      pend_status <= 1'b0;
    end
    // The last segment closes with its end control point as one more word.
    if (push_p3) begin
      pend_x      <= bx[3] ^ SIGN_FLIP;
      pend_y      <= by[3] ^ SIGN_FLIP;
      pend_last   <= 1'b1;
      pend_status <= 1'b0;
    end
    if (push_next) begin
      rem_t <= t_carry ? PW'(rem_sum - {1'b0, pps_eff}) : rem_sum[PW-1:0];
      t     <= t + div_quo[15:0] + 16'(t_carry);
    end
    if (push) begin
      point_x <= pend_x;
      point_y <= pend_y;
      last    <= pend_last;
      status  <= pend_status;
    end
  end

  // Product writeback: weight registers, then the exact 64-bit weighted sums.
  always_ff @(posedge clk) begin
    if ((state == S_MUL) && (step == '0)) begin
      acc_x <= '0;
      acc_y <= '0;
    end
    case (prod_dest)
      DST_UU:  uu   <= prod[32:0];
      DST_UT:  ut   <= prod[31:0];
      DST_TT:  tt   <= prod[31:0];
      DST_W0:  w[0] <= prod[W_W-1:0];
      DST_W1:  w[1] <= prod[W_W-1:0] + {prod[W_W-2:0], 1'b0};
      DST_W2:  w[2] <= prod[W_W-1:0] + {prod[W_W-2:0], 1'b0};
      DST_W3:  w[3] <= prod[W_W-1:0];
      DST_XLO: acc_x <= acc_x + ACC_W'(prod);
      DST_XHI: acc_x <= acc_x + (ACC_W'(prod) << bct_pkg::MUL_A_W);
      DST_YLO: acc_y <= acc_y + ACC_W'(prod);
      DST_YHI: acc_y <= acc_y + (ACC_W'(prod) << bct_pkg::MUL_A_W);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/bct_store.sv
// Control point store: one write port and one registered read port, x and y side by side.
// Depends on bct_pkg for the depth and coordinate width.
`default_nettype none

module bct_store (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [bct_pkg::ADDR_W-1:0]   waddr,
  input  wire logic [bct_pkg::COORD_W-1:0]  wr_x,
  input  wire logic [bct_pkg::COORD_W-1:0]  wr_y,
  input  wire logic [bct_pkg::ADDR_W-1:0]   raddr,
  output logic      [bct_pkg::COORD_W-1:0]  rd_x,
  output logic      [bct_pkg::COORD_W-1:0]  rd_y
);

  logic [2*bct_pkg::COORD_W-1:0] mem [0:bct_pkg::STORE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wr_x, wr_y};
    end
  end

  always_ff @(posedge clk) begin
    {rd_x, rd_y} <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/bct_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on bct_pkg for the operand widths.
`default_nettype none

module bct_mul (
  input  wire logic                         clk,
  input  wire logic [bct_pkg::MUL_A_W-1:0]  a,
  input  wire logic [bct_pkg::MUL_B_W-1:0]  b,
  output logic      [bct_pkg::MUL_P_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= bct_pkg::MUL_P_W'(a) * bct_pkg::MUL_P_W'(b);
  end

endmodule

`default_nettype wire

### rtl/bct_div.sv
// Restoring divider, one quotient bit per cycle: computes one unit of t (2^16)
// divided by the sample count. Depends on bct_pkg.
`default_nettype none

module bct_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bct_pkg::PPS_W-1:0]   divisor,
  output logic      [bct_pkg::QUO_W-1:0]   quotient,
  output logic      [bct_pkg::PPS_W-1:0]   remainder,
  output logic                             done
);

  localparam int CNT_W = $clog2(bct_pkg::QUO_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [bct_pkg::PPS_W:0] rem_sh;
  logic [bct_pkg::PPS_W:0] diff;
  logic                    fits;

  always_comb begin
    rem_sh = {remainder, quotient[bct_pkg::QUO_W-1]};
    fits   = rem_sh >= {1'b0, divisor};
    diff   = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(bct_pkg::QUO_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // The quotient register starts as the dividend and fills with quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= bct_pkg::T_ONE;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[bct_pkg::QUO_W-2:0], fits};
      remainder <= fits ? diff[bct_pkg::PPS_W-1:0] : rem_sh[bct_pkg::PPS_W-1:0];
    end
  end

endmodule

`default_nettype wire
